// ===== hw/rtl/srle_pkg.sv =====
// Shared types and constants for the snapshot run-length encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package srle_pkg;

    localparam logic [7:0] CODE_MARK = 8'hED;
    localparam logic [7:0] MIN_CODED = 8'd4;
    localparam logic [7:0] MAX_RUN   = 8'd255;

    // command queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // positions of the count and value bytes inside ED ED count value
    localparam logic [2:0] CODE_IDX_COUNT = 3'd2;
    localparam logic [2:0] CODE_IDX_VALUE = 3'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       item_last;
        logic       block_done;
    } t_out_item;

    typedef enum logic [1:0] {
        FLUSH_NONE,
        FLUSH_CODE,
        FLUSH_LIT
    } t_flush_kind;

    // one item's worth of output work
    typedef struct packed {
        t_flush_kind flush_kind;
        logic [7:0]  count;
        logic [7:0]  value;
        logic        tail_en;
        logic [7:0]  tail_byte;
        logic        blk_last;
    } t_cmd;

    typedef enum logic {
        BK_FLUSH,
        BK_TAIL
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/snapshot_rle_encoder_unit.sv =====
// Snapshot run-length encoder, ED ED count value code. An item whose byte
// only extends the pending run produces no output; an item that produces n
// bytes (one to five) holds the back-end sequencer until its last byte is
// out, since the output register takes one byte per cycle while the
// receiver is not stalling it. The front end accepts a new item every cycle
// while the two-entry command queue has room, so short bursts are absorbed
// and the sustained rate is set by the number of output bytes. The first
// output byte of an item passes through the command queue and then the
// output register. Depends on srle_pkg, srle_front, srle_queue, srle_back.
`default_nettype none

module snapshot_rle_encoder_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire srle_pkg::t_in_item  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output srle_pkg::t_out_item      o_data
);

    logic           push, q_ready, q_valid, pop;
    srle_pkg::t_cmd f_cmd, q_cmd;

    srle_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_push    (push),
        .o_cmd     (f_cmd),
        .i_q_ready (q_ready)
    );

    srle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    srle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/srle_front.sv =====
// Front end: accepts items, holds the pending run and issues output commands.
// Depends on srle_pkg.
`default_nettype none

module srle_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire srle_pkg::t_in_item i_data,
    output logic                    o_push,
    output srle_pkg::t_cmd          o_cmd,
    input  wire logic               i_q_ready
);

    logic [7:0] r_prev_byte, n_prev_byte;
    logic       r_prev_valid, n_prev_valid;
    logic [7:0] r_run_length, n_run_length;

    logic           accept;
    logic [7:0]     run_inc;
    logic           after_mark;
    srle_pkg::t_cmd cmd;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign run_inc = r_run_length + 8'd1;

    always_comb begin
        cmd          = '0;
        cmd.flush_kind = srle_pkg::FLUSH_NONE;
        cmd.blk_last = i_data.block_last;
        cmd.tail_byte = i_data.data_byte;
        n_prev_byte  = r_prev_byte;
        n_prev_valid = r_prev_valid;
        n_run_length = r_run_length;
        after_mark   = r_prev_valid && (r_prev_byte == srle_pkg::CODE_MARK);
        if (r_prev_valid && (i_data.data_byte == r_prev_byte)) begin
            n_run_length = run_inc;
            if ((run_inc >= srle_pkg::MAX_RUN) || i_data.block_last || after_mark) begin
                cmd.flush_kind = srle_pkg::FLUSH_CODE;
                cmd.count      = run_inc;
                cmd.value      = r_prev_byte;
                n_prev_byte    = '0;
                n_prev_valid   = 1'b0;
                n_run_length   = '0;
            end
        end else begin
            cmd.count = r_run_length;
            cmd.value = r_prev_byte;
            if (r_prev_valid && (r_run_length > srle_pkg::MIN_CODED)) begin
                cmd.flush_kind = srle_pkg::FLUSH_CODE;
            end else if (r_prev_valid) begin
                cmd.flush_kind = srle_pkg::FLUSH_LIT;
            end
            if (after_mark || i_data.block_last) begin
                cmd.tail_en  = 1'b1;
                n_prev_byte  = '0;
                n_prev_valid = 1'b0;
                n_run_length = '0;
            end else begin
                n_prev_byte  = i_data.data_byte;
                n_prev_valid = 1'b1;
                n_run_length = 8'd1;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((cmd.flush_kind != srle_pkg::FLUSH_NONE) || cmd.tail_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte  <= '0;
            r_prev_valid <= 1'b0;
            r_run_length <= '0;
        end else if (accept) begin
            r_prev_byte  <= n_prev_byte;
            r_prev_valid <= n_prev_valid;
            r_run_length <= n_run_length;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_prev_valid |-> (r_run_length == 8'd0 && r_prev_byte == 8'd0))
        else $error("srle_front: idle state not cleared");

    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_valid |-> (r_run_length != 8'd0 && r_run_length < srle_pkg::MAX_RUN))
        else $error("srle_front: run length out of range");

    a_mark_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_valid && r_prev_byte == srle_pkg::CODE_MARK) |-> r_run_length == 8'd1)
        else $error("srle_front: pending mark run longer than one");

endmodule

`default_nettype wire

// ===== hw/rtl/srle_queue.sv =====
// Short command queue between front and back end.
// Depends on srle_pkg.
`default_nettype none

module srle_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire srle_pkg::t_cmd i_cmd,
    output logic                o_ready,
    output logic                o_valid,
    output srle_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);

    srle_pkg::t_cmd r_mem [srle_pkg::QUEUE_DEPTH];
    logic [srle_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [srle_pkg::QCNT_W-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_ready = (r_count != srle_pkg::QCNT_W'(srle_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/srle_back.sv =====
// Back end: expands queued commands into output bytes through an output
// register, one per cycle unless the receiver stalls. Depends on srle_pkg.
`default_nettype none

module srle_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  wire srle_pkg::t_cmd      i_cmd,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output srle_pkg::t_out_item      o_data
);

    srle_pkg::t_back_state r_state, n_state;
    logic [2:0]            r_idx, n_idx;
    logic                  r_out_valid;
    srle_pkg::t_out_item   r_out;

    logic       emit;
    logic       tail_now;
    logic       flush_end;
    logic       item_end;
    logic [7:0] cur_byte;

    assign emit = i_q_valid && (!r_out_valid || i_ready);

    // output decode
    always_comb begin
        tail_now  = (r_state == srle_pkg::BK_TAIL) ||
                    (i_cmd.flush_kind == srle_pkg::FLUSH_NONE);
        flush_end = 1'b0;
        cur_byte  = i_cmd.tail_byte;
        if (!tail_now) begin
            unique case (i_cmd.flush_kind)
                srle_pkg::FLUSH_CODE: begin
                    flush_end = (r_idx == srle_pkg::CODE_IDX_VALUE);
                    if (r_idx == srle_pkg::CODE_IDX_VALUE) begin
                        cur_byte = i_cmd.value;
                    end else if (r_idx == srle_pkg::CODE_IDX_COUNT) begin
                        cur_byte = i_cmd.count;
                    end else begin
                        cur_byte = srle_pkg::CODE_MARK;
                    end
                end
                srle_pkg::FLUSH_LIT: begin
                    flush_end = (r_idx == (i_cmd.count[2:0] - 3'd1));
                    cur_byte  = i_cmd.value;
                end
                default: begin
                    flush_end = 1'b1;
                end
            endcase
        end
        item_end = tail_now || (flush_end && !i_cmd.tail_en);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (emit) begin
            if (item_end) begin
                n_state = srle_pkg::BK_FLUSH;
                n_idx   = '0;
            end else if (flush_end) begin
                n_state = srle_pkg::BK_TAIL;
                n_idx   = '0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    assign o_pop = emit && item_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srle_pkg::BK_FLUSH;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_byte   <= cur_byte;
            r_out.item_last  <= item_end;
            r_out.block_done <= item_end && i_cmd.blk_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_tail_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srle_pkg::BK_TAIL) |-> (i_q_valid && i_cmd.tail_en))
        else $error("srle_back: tail phase without tail byte");

    a_lit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && r_state == srle_pkg::BK_FLUSH &&
         i_cmd.flush_kind == srle_pkg::FLUSH_LIT) |->
        (i_cmd.count != 8'd0 && i_cmd.count <= srle_pkg::MIN_CODED &&
         r_idx < i_cmd.count[2:0]))
        else $error("srle_back: literal copy index out of range");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.block_done) |-> r_out.item_last)
        else $error("srle_back: block end not on last byte of item");

endmodule

`default_nettype wire

// ===== tb/snapshot_rle_encoder_unit_tb.sv =====
// Self-checking bench for snapshot_rle_encoder_unit: queue-fed driver, clocked
// monitor and an ED ED count value encoder model that predicts every output byte.
// Depends on srle_pkg. Runs directed corner items, then random runs under back-pressure.
module snapshot_rle_encoder_unit_tb;
    import srle_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_STALL  = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    t_in_item  byte_feed[$];
    t_out_item expected_bytes[$];
    t_out_item burst_bytes[$];

    logic [7:0] run_byte = '0;
    logic       run_live = 1'b0;
    logic [7:0] run_count = '0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic in_fire = 1'b0;
    logic long_stall_req = 1'b0;
    logic long_stall_done = 1'b0;
    int  stall_left = 0;
    int  cycle_count = 0;
    int  mismatch_count = 0;

    snapshot_rle_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function void emit_byte(input logic [7:0] v);
        t_out_item o;
        o.out_byte   = v;
        o.item_last  = 1'b0;
        o.block_done = 1'b0;
        burst_bytes.push_back(o);
    endfunction

    function void emit_code(input logic [7:0] count, input logic [7:0] v);
        emit_byte(CODE_MARK);
        emit_byte(CODE_MARK);
        emit_byte(count);
        emit_byte(v);
    endfunction

    function void clear_run();
        run_byte  = '0;
        run_live  = 1'b0;
        run_count = '0;
    endfunction

    function void encode_item(input t_in_item it);
        logic after_mark;
        t_out_item tail;
        burst_bytes.delete();
        if (run_live && it.data_byte == run_byte) begin
            run_count = run_count + 8'd1;
            if (run_count >= MAX_RUN || it.block_last || run_byte == CODE_MARK) begin
                emit_code(run_count, run_byte);
                clear_run();
            end
        end else begin
            after_mark = run_live && run_byte == CODE_MARK;
            if (run_live && run_count > MIN_CODED) begin
                emit_code(run_count, run_byte);
            end else if (run_live) begin
                for (int k = 0; k < run_count; k++) emit_byte(run_byte);
            end
            if (after_mark || it.block_last) begin
                emit_byte(it.data_byte);
                clear_run();
            end else begin
                run_byte  = it.data_byte;
                run_live  = 1'b1;
                run_count = 8'd1;
            end
        end
        if (burst_bytes.size() > 0) begin
            tail = burst_bytes.pop_back();
            tail.item_last  = 1'b1;
            tail.block_done = it.block_last;
            burst_bytes.push_back(tail);
        end
        foreach (burst_bytes[k]) expected_bytes.push_back(burst_bytes[k]);
    endfunction

    function void push_item(input logic [7:0] v, input logic last_flag);
        t_in_item it;
        it.data_byte  = v;
        it.block_last = last_flag;
        byte_feed.push_back(it);
    endfunction

    function logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25) return CODE_MARK;
        if (r < 35) return 8'h00;
        if (r < 45) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic gen_mix(input int n_items);
        int made;
        int len;
        int r;
        logic [7:0] v;
        logic fin;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(99);
            if (r < 65) begin
                v   = pick_byte();
                len = $urandom_range(1, 9);
                fin = ($urandom_range(5) == 0);
                for (int k = 0; k < len; k++) push_item(v, fin && (k == len - 1));
                made += len;
            end else if (r < 80) begin
                push_item(CODE_MARK, 1'b0);
                push_item(pick_byte(), $urandom_range(3) == 0);
                made += 2;
            end else begin
                push_item(8'($urandom_range(255)), $urandom_range(7) == 0);
                made += 1;
            end
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (byte_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_data  <= byte_feed.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            i_ready         <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_valid && o_ready;
            if (i_valid && o_ready) encode_item(i_data);
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: mismatch expected none, actual byte=%h last=%b done=%b",
                             $time, o_data.out_byte, o_data.item_last, o_data.block_done);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_data !== want) begin
                        $display({"%0t: mismatch expected byte=%h last=%b done=%b,",
                                  " actual byte=%h last=%b done=%b"},
                                 $time, want.out_byte, want.item_last, want.block_done,
                                 o_data.out_byte, o_data.item_last, o_data.block_done);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[snapshot_rle_encoder_unit] ERROR");
            $finish;
        end
    end

    initial begin
        // directed corners
        repeat (5) push_item(8'h00, 1'b0);
        push_item(8'h01, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(CODE_MARK, 1'b0);
        push_item(CODE_MARK, 1'b0);
        push_item(CODE_MARK, 1'b0);
        push_item(8'h41, 1'b0);
        repeat (3) push_item(8'h12, 1'b0);
        push_item(8'h34, 1'b1);
        push_item(CODE_MARK, 1'b1);
        push_item(8'h7F, 1'b0);
        push_item(8'h80, 1'b1);
        repeat (4) push_item(8'h55, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'hAA, 1'b1);

        send_idle_pct = 30;
        recv_idle_pct = 51;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        gen_mix(60);
        while (byte_feed.size() != 0) @(posedge i_clk);
        // let the pipe drain completely before going on
        while (i_valid || expected_bytes.size() != 0) @(posedge i_clk);

        send_idle_pct = 51;
        recv_idle_pct = 30;
        gen_mix(60);
        while (byte_feed.size() != 0) @(posedge i_clk);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_mix(30);
        repeat (256) push_item(8'h3C, 1'b0);
        push_item(8'h3C, 1'b1);
        gen_mix(30);
        long_stall_req = 1'b1;

        while (byte_feed.size() != 0 || i_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("[snapshot_rle_encoder_unit] OK");
        end else begin
            $display("[snapshot_rle_encoder_unit] ERROR");
        end
        $finish;
    end
endmodule
